// ===== design/hhef_pkg.sv =====
// Shared types and constants of the half-height edge finder.
package hhef_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_THRESHOLD       = 2'd0;
    localparam logic [1:0] CFG_BASELINE        = 2'd1;
    localparam logic [1:0] CFG_TIME_PER_SAMPLE = 2'd2;
    localparam logic [1:0] CFG_TIME_OFFSET     = 2'd3;

    // Register reset values.
    localparam logic signed [15:0] THRESHOLD_RST = 16'sd100;
    localparam logic [19:0]        TPS_RST       = 20'd256;

    // Largest edge position (20 bits, 8 fractional).
    localparam int unsigned POS_MAX = 1048575;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EVAL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PREV_RD,
        ST_PREV_CHK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_POS,
        ST_MUL,
        ST_TIME
    } t_state;

    // Status of the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// ===== design/hhef_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hhef_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/hhef_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, unsigned operands.
module hhef_div #(
    parameter int NW = 42,
    parameter int DW = 26
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NW-1:0]        i_num,
    input  logic [DW-1:0]        i_den,
    output logic [NW-1:0]        o_quo,
    output logic                 o_rem_nz,
    output hhef_pkg::t_div_status o_status
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   r_quo, n_quo;
    logic [DW-1:0]   r_rem, n_rem;
    logic [DW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [DW:0]     w_shift;
    logic [DW:0]     w_diff;

    always_comb begin
        w_shift = {r_rem, r_quo[NW-1]};
        w_diff  = w_shift - {1'b0, r_den};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_shift >= {1'b0, r_den}) begin
                n_rem = w_diff[DW-1:0];
                n_quo = {r_quo[NW-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DW-1:0];
                n_quo = {r_quo[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNTW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_quo           = r_quo;
    assign o_rem_nz        = (r_rem != '0);
    assign o_status.busy   = r_busy;
    assign o_status.done   = r_done;

endmodule

// ===== design/waveform_half_height_edge_finder.sv =====
// Half-height edge finder: finds the 50 percent crossing of each pulse in a waveform.
//
// Samples arrive one transaction at a time on the input channel; a sample with
// first set starts a new waveform, clears the pulse state and latches the scale
// (zero counts as one) that multiplies threshold and baseline. Every sample is
// written into a sample memory of MAX_SAMPLES entries; samples beyond that are
// dropped until the next first sample. When a pulse closes, a sequencer walks
// the memory from the pulse start for the first sample at or past half height,
// reads its predecessor (unless it is at address zero), and an iterative divider
// interpolates the crossing to 8 fractional bits; one result transaction carries
// the position and the derived edge time. An ordinary sample passes through accept,
// scale load and evaluate. A closing sample then adds a read and a check state for
// each sample scanned (the memory read is registered), a read and a check state to
// fetch the previous sample, a start and a wait state for the divider (of width
// NW = max(SAMPLE_BITS,24)+10, 34 at the defaults), and states for position,
// multiply and time. The output register holds a result until it is taken, so a
// new sample may be accepted meanwhile; the sequencer only stalls at the end of the
// next pulse if the previous result is still waiting. Configuration writes are
// always accepted and are meant for idle periods; threshold and baseline take
// effect at the next first sample, the time registers at once.
module waveform_half_height_edge_finder #(
    parameter int MAX_SAMPLES = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_first,
    input  logic [7:0]                    i_scale,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [19:0]                   o_edge_position,
    output logic signed [33:0]            o_edge_time,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    // Index and count widths for the sample memory.
    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    // Level (peak plus baseline) width, numerator and denominator widths.
    localparam int MW = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
    localparam int LW = MW + 2;
    localparam int NW = LW + 8;
    localparam int DW = SAMPLE_BITS + 2;
    localparam int PW = ((NW > IW + 8) ? NW : IW + 8) + 2;

    hhef_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic signed [15:0] r_thr;
    logic signed [15:0] r_base;
    logic [19:0]        r_tps;
    logic signed [31:0] r_toff;

    // Waveform state.
    logic [CW-1:0]                 r_cnt;
    logic                          r_in_pulse;
    logic [IW-1:0]                 r_pstart;
    logic signed [SAMPLE_BITS-1:0] r_peak;
    logic signed [23:0]            r_sthr;
    logic signed [23:0]            r_sbase;
    logic                          r_rise;

    // Held input transaction.
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic                          r_first;
    logic [7:0]                    r_scale;

    // Edge search working registers.
    logic [IW-1:0]                 r_idx;
    logic [CW-1:0]                 r_end;
    logic signed [LW-1:0]          r_level;
    logic signed [SAMPLE_BITS-1:0] r_ci;
    logic [NW-1:0]                 r_nmag;
    logic [DW-1:0]                 r_dmag;
    logic                          r_qneg;
    logic                          r_dzero;
    logic [19:0]                   r_upos;
    logic [39:0]                   r_prod;

    // Output register.
    logic                          r_out_valid;
    logic [19:0]                   r_out_pos;
    logic signed [33:0]            r_out_time;

    // Memory and divider connections.
    logic                          w_we;
    logic [IW-1:0]                 w_raddr;
    logic [SAMPLE_BITS-1:0]        w_rdata;
    logic signed [SAMPLE_BITS-1:0] w_c;
    logic                          w_div_start;
    logic [NW-1:0]                 w_quo;
    logic                          w_rem_nz;
    hhef_pkg::t_div_status         w_div_st;

    // Combinational helpers.
    logic                          w_in_acc;
    logic signed [8:0]             w_sc;
    logic signed [24:0]            w_thr_x;
    logic signed [24:0]            w_base_x;
    logic signed [LW-1:0]          w_y;
    logic                          w_over;
    logic                          w_peak_upd;
    logic signed [LW-1:0]          w_c2;
    logic                          w_hit;
    logic signed [LW-1:0]          w_diff;
    logic signed [NW-1:0]          w_num;
    logic signed [DW-1:0]          w_den;
    logic signed [NW:0]            w_frac;
    logic signed [PW-1:0]          w_pos;
    logic signed [33:0]            w_time;

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_c      = $signed(w_rdata);

    // Scale of the held sample, used when it is a first sample; zero means one.
    always_comb begin
        w_sc     = (r_scale == 8'd0) ? 9'sd1 : $signed({1'b0, r_scale});
        w_thr_x  = r_thr * w_sc;
        w_base_x = r_base * w_sc;
    end

    // Threshold test and peak tracking on the held sample.
    always_comb begin
        w_y    = LW'(r_smp);
        w_over = r_rise ? (w_y > LW'(r_sthr)) : (w_y < LW'(r_sthr));
        w_peak_upd = r_rise ? (r_smp > r_peak) : (r_smp < r_peak);
    end

    // Half-height test on the sample just read.
    always_comb begin
        w_c2  = LW'(w_c) <<< 1;
        w_hit = r_rise ? (w_c2 >= r_level) : (w_c2 <= r_level);
    end

    // Interpolation operands, with c[i] held and c[i-1] on the read port.
    always_comb begin
        w_diff = r_level - (LW'(r_ci) <<< 1);
        w_num  = NW'(w_diff) <<< 8;
        w_den  = (DW'(r_ci) - DW'(w_c)) <<< 1;
    end

    // Floor quotient and saturated position.
    always_comb begin
        if (r_dzero) begin
            w_frac = '0;
        end else if (r_qneg) begin
            w_frac = -($signed({1'b0, w_quo}) + (NW + 1)'(w_rem_nz));
        end else begin
            w_frac = $signed({1'b0, w_quo});
        end
        w_pos = $signed(PW'({r_idx, 8'd0})) + PW'(w_frac);
    end

    assign w_time = $signed({10'd0, r_prod[39:16]}) + 34'(r_toff);

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        w_we        = 1'b0;
        w_raddr     = r_idx;
        w_div_start = 1'b0;
        case (r_state)
            hhef_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = hhef_pkg::ST_LOAD;
                end
            end
            hhef_pkg::ST_LOAD: begin
                n_state = hhef_pkg::ST_EVAL;
            end
            hhef_pkg::ST_EVAL: begin
                if (r_cnt == CW'(MAX_SAMPLES)) begin
                    n_state = hhef_pkg::ST_IDLE;
                end else begin
                    w_we = 1'b1;
                    if (r_in_pulse && !w_over) begin
                        n_state = hhef_pkg::ST_SCAN_RD;
                    end else begin
                        n_state = hhef_pkg::ST_IDLE;
                    end
                end
            end
            hhef_pkg::ST_SCAN_RD: begin
                n_state = hhef_pkg::ST_SCAN_CHK;
            end
            hhef_pkg::ST_SCAN_CHK: begin
                if ((CW'(r_idx) + 1'b1 < r_end) && !w_hit) begin
                    n_state = hhef_pkg::ST_SCAN_RD;
                end else if (r_idx == '0) begin
                    n_state = hhef_pkg::ST_MUL;
                end else begin
                    n_state = hhef_pkg::ST_PREV_RD;
                end
            end
            hhef_pkg::ST_PREV_RD: begin
                w_raddr = r_idx - 1'b1;
                n_state = hhef_pkg::ST_PREV_CHK;
            end
            hhef_pkg::ST_PREV_CHK: begin
                n_state = hhef_pkg::ST_DIV_GO;
            end
            hhef_pkg::ST_DIV_GO: begin
                if (r_dzero) begin
                    n_state = hhef_pkg::ST_POS;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = hhef_pkg::ST_DIV_WAIT;
                end
            end
            hhef_pkg::ST_DIV_WAIT: begin
                if (w_div_st.done) begin
                    n_state = hhef_pkg::ST_POS;
                end
            end
            hhef_pkg::ST_POS: begin
                n_state = hhef_pkg::ST_MUL;
            end
            hhef_pkg::ST_MUL: begin
                n_state = hhef_pkg::ST_TIME;
            end
            hhef_pkg::ST_TIME: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = hhef_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hhef_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hhef_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= hhef_pkg::THRESHOLD_RST;
            r_base <= '0;
            r_tps  <= hhef_pkg::TPS_RST;
            r_toff <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hhef_pkg::CFG_THRESHOLD:       r_thr  <= i_cfg_data[15:0];
                hhef_pkg::CFG_BASELINE:        r_base <= i_cfg_data[15:0];
                hhef_pkg::CFG_TIME_PER_SAMPLE: r_tps  <= i_cfg_data[19:0];
                hhef_pkg::CFG_TIME_OFFSET:     r_toff <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Waveform state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_in_pulse  <= 1'b0;
            r_pstart    <= '0;
            r_peak      <= '0;
            r_sthr      <= '0;
            r_sbase     <= '0;
            r_rise      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            // A finished result loads the output register once it is free.
            if ((r_state == hhef_pkg::ST_TIME) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                hhef_pkg::ST_LOAD: begin
                    if (r_first) begin
                        r_cnt      <= '0;
                        r_in_pulse <= 1'b0;
                        r_pstart   <= '0;
                        r_peak     <= '0;
                        r_sthr     <= w_thr_x[23:0];
                        r_sbase    <= w_base_x[23:0];
                        r_rise     <= (w_thr_x > w_base_x);
                    end
                end
                hhef_pkg::ST_EVAL: begin
                    if (r_cnt != CW'(MAX_SAMPLES)) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (!r_in_pulse && w_over) begin
                            r_in_pulse <= 1'b1;
                            r_pstart   <= r_cnt[IW-1:0];
                            r_peak     <= r_smp;
                        end else if (r_in_pulse && !w_over) begin
                            r_in_pulse <= 1'b0;
                        end else if (w_peak_upd) begin
                            r_peak <= r_smp;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_smp   <= i_sample;
            r_first <= i_first;
            r_scale <= i_scale;
        end
        case (r_state)
            hhef_pkg::ST_EVAL: begin
                r_idx   <= r_pstart;
                r_end   <= r_cnt;
                r_level <= LW'(r_peak) + LW'(r_sbase);
            end
            hhef_pkg::ST_SCAN_CHK: begin
                r_ci   <= w_c;
                r_upos <= '0;
                if ((CW'(r_idx) + 1'b1 < r_end) && !w_hit) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            hhef_pkg::ST_PREV_CHK: begin
                r_nmag  <= w_num[NW-1] ? NW'(-w_num) : NW'(w_num);
                r_dmag  <= w_den[DW-1] ? DW'(-w_den) : DW'(w_den);
                r_qneg  <= w_num[NW-1] ^ w_den[DW-1];
                r_dzero <= (w_den == '0);
            end
            hhef_pkg::ST_POS: begin
                if (w_pos < 0) begin
                    r_upos <= '0;
                end else if (w_pos > PW'(hhef_pkg::POS_MAX)) begin
                    r_upos <= 20'(hhef_pkg::POS_MAX);
                end else begin
                    r_upos <= w_pos[19:0];
                end
            end
            hhef_pkg::ST_MUL: begin
                r_prod <= r_upos * r_tps;
            end
            hhef_pkg::ST_TIME: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out_pos  <= r_upos;
                    r_out_time <= w_time;
                end
            end
            default: begin
            end
        endcase
    end

    hhef_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (r_smp),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hhef_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (r_nmag),
        .i_den    (r_dmag),
        .o_quo    (w_quo),
        .o_rem_nz (w_rem_nz),
        .o_status (w_div_st)
    );

    assign o_in_ready      = (r_state == hhef_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_edge_position = r_out_pos;
    assign o_edge_time     = r_out_time;

endmodule

// ===== design/hhef_checker.sv =====
// Port-level checker for the half-height edge finder, with its bind.
module hhef_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [19:0] o_edge_position,
    input logic [33:0] o_edge_time
);

    // A pending result holds its payload until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_edge_position)
        && $stable(o_edge_time))
        else $error("result changed while stalled");

    // The block is busy in the cycle after taking a sample.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("sample accepted back to back");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("bad state after reset");

    // A new result never appears while the sample side is idle-waiting.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without work");

endmodule

bind waveform_half_height_edge_finder hhef_checker u_hhef_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_edge_position (o_edge_position),
    .o_edge_time     (o_edge_time)
);
